// ===== src/haar2d_pkg.sv =====
// ----------------------------------------------------------------------------
// haar2d_pkg
// Shared types and constants for the multi-level 2D Haar forward transform.
// ----------------------------------------------------------------------------
package haar2d_pkg;

   // default geometry, handed to the top level parameters
   localparam int DEF_IMAGE_WIDTH  = 256;
   localparam int DEF_IMAGE_HEIGHT = 256;
   localparam int DEF_MAX_LEVELS   = 8;

   // stored coefficient width and width of the four-term sums
   localparam int STORE_W = 18;
   localparam int SUM_W   = 20;
   localparam int COEF_W  = 17;

   localparam int          LEVEL_W     = 4;
   localparam logic [3:0]  LEVEL_RESET = 4'd3;

   // request kinds
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_STORED = 2'd0;
   localparam logic [1:0] STATUS_COEF   = 2'd1;
   localparam logic [1:0] STATUS_DONE   = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] row;
      logic [7:0] column;
      logic [7:0] pixel_value;
   } req_word_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic [1:0]               status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_CLEAR,
      ENG_LEVEL,
      ENG_COPY,
      ENG_CALC
   } eng_state_type;

   // engine to top level memory strobes and status
   typedef struct packed {
      logic busy;
      logic done;
      logic img_rd;
      logic scr_rd;
      logic scr_wr;
   } eng_ctl_type;

endpackage

// ===== src/haar2d_engine.sv =====
// ----------------------------------------------------------------------------
// haar2d_engine
// Transform sequencer: clears the coefficient store, copies each level's
// input band into a work memory and runs every 2x2 block through one shared
// add/subtract unit.
// ----------------------------------------------------------------------------
module haar2d_engine #(
   parameter int  IMAGE_WIDTH  = haar2d_pkg::DEF_IMAGE_WIDTH,
   parameter int  IMAGE_HEIGHT = haar2d_pkg::DEF_IMAGE_HEIGHT,
   parameter int  MAX_LEVELS   = haar2d_pkg::DEF_MAX_LEVELS,
   localparam int COL_W        = $clog2(IMAGE_WIDTH),
   localparam int ROW_W        = $clog2(IMAGE_HEIGHT),
   localparam int ADDR_W       = COL_W + ROW_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [haar2d_pkg::LEVEL_W-1:0]      level_count,
   input  logic [haar2d_pkg::STORE_W-1:0]      img_rd_data,
   input  logic [haar2d_pkg::STORE_W-1:0]      scr_rd_data,
   output haar2d_pkg::eng_ctl_type             ctl,
   output logic [ADDR_W-1:0]                   img_rd_addr,
   output logic [ADDR_W-1:0]                   scr_rd_addr,
   output logic [ADDR_W-1:0]                   scr_wr_addr,
   output logic [haar2d_pkg::STORE_W-1:0]      scr_wr_data
);
   import haar2d_pkg::*;

   localparam int DEPTH  = 1 << ADDR_W;
   localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
   localparam int STEP_W = 4;

   // block steps: four reads, a capture of the last read, four butterflies, four stores
   localparam logic [STEP_W-1:0] STEP_RD_A  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_RD_B  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_RD_C  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_RD_D  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_GET_D = 4'd4;
   localparam logic [STEP_W-1:0] STEP_P     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_Q     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_R     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_S     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_LL    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_LH    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_HL    = 4'd11;
   localparam logic [STEP_W-1:0] STEP_HH    = 4'd12;

   eng_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ROW_W-1:0]  cy_ff, cy_in;
   logic [COL_W-1:0]  cx_ff, cx_in;
   logic [ROW_W:0]    h_ff, h_in;
   logic [COL_W:0]    w_ff, w_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [LVL_W-1:0]  lvl_max_ff, lvl_max_in;

   logic signed [STORE_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic signed [SUM_W-1:0]   p_ff, p_in, q_ff, q_in, r_ff, r_in, s_ff, s_in;

   logic              sw_wr_ff, sw_wr_in;
   logic              sw_src_ff, sw_src_in;
   logic [ADDR_W-1:0] sw_addr_ff, sw_addr_in;

   logic [STORE_W-1:0] work_mem [DEPTH];
   logic [STORE_W-1:0] work_rd_data_ff;
   logic               work_rd_en;
   logic [ADDR_W-1:0]  work_rd_addr;

   logic signed [SUM_W-1:0] alu_a, alu_b, alu_res;
   logic                    alu_sub;

   logic [ROW_W:0]   lim_y;
   logic [COL_W:0]   lim_x;
   logic             sweep_last_x, sweep_last_y;
   logic             blk_last_x, blk_last_y;
   logic [ROW_W-1:0] row_even, row_odd, row_low;
   logic [COL_W-1:0] col_even, col_odd, col_high;

   // shared add/subtract unit
   assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

   always_comb begin
      lim_y = (state_ff == ENG_CLEAR) ? (ROW_W+1)'(IMAGE_HEIGHT) : (h_ff << 1);
      lim_x = (state_ff == ENG_CLEAR) ? (COL_W+1)'(IMAGE_WIDTH) : (w_ff << 1);
      sweep_last_x = ({1'b0, cx_ff} == (lim_x - (COL_W+1)'(1)));
      sweep_last_y = ({1'b0, cy_ff} == (lim_y - (ROW_W+1)'(1)));
      blk_last_x   = ({1'b0, cx_ff} == (w_ff - (COL_W+1)'(1)));
      blk_last_y   = ({1'b0, cy_ff} == (h_ff - (ROW_W+1)'(1)));
      row_even = ROW_W'({cy_ff, 1'b0});
      row_odd  = ROW_W'({cy_ff, 1'b1});
      col_even = COL_W'({cx_ff, 1'b0});
      col_odd  = COL_W'({cx_ff, 1'b1});
      row_low  = ROW_W'({1'b0, cy_ff} + h_ff);
      col_high = COL_W'({1'b0, cx_ff} + w_ff);
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cy_in      = cy_ff;
      cx_in      = cx_ff;
      h_in       = h_ff;
      w_in       = w_ff;
      lvl_in     = lvl_ff;
      lvl_max_in = lvl_max_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      p_in = p_ff;
      q_in = q_ff;
      r_in = r_ff;
      s_in = s_ff;
      sw_wr_in   = 1'b0;
      sw_src_in  = sw_src_ff;
      sw_addr_in = sw_addr_ff;
      ctl          = '0;
      ctl.busy     = (state_ff != ENG_IDLE);
      img_rd_addr  = '0;
      scr_rd_addr  = '0;
      scr_wr_addr  = '0;
      scr_wr_data  = '0;
      work_rd_en   = 1'b0;
      work_rd_addr = '0;
      alu_a   = SUM_W'(a_ff);
      alu_b   = SUM_W'(b_ff);
      alu_sub = 1'b0;

      case (state_ff)
         ENG_IDLE: begin
            if (start) begin
               lvl_max_in = (32'(level_count) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS)
                                                           : LVL_W'(level_count);
               lvl_in   = '0;
               w_in     = (COL_W+1)'(IMAGE_WIDTH);
               h_in     = (ROW_W+1)'(IMAGE_HEIGHT);
               cy_in    = '0;
               cx_in    = '0;
               state_in = ENG_CLEAR;
            end
         end

         ENG_CLEAR, ENG_COPY: begin
            // clear: zero the coefficients and pull the image into the work store
            // copy: pull the current band of coefficients into the work store
            if (state_ff == ENG_CLEAR) begin
               ctl.img_rd  = 1'b1;
               img_rd_addr = {cy_ff, cx_ff};
               ctl.scr_wr  = 1'b1;
               scr_wr_addr = {cy_ff, cx_ff};
               sw_src_in   = 1'b0;
            end else begin
               ctl.scr_rd  = 1'b1;
               scr_rd_addr = {cy_ff, cx_ff};
               sw_src_in   = 1'b1;
            end
            sw_wr_in   = 1'b1;
            sw_addr_in = {cy_ff, cx_ff};
            if (sweep_last_x) begin
               cx_in = '0;
               if (sweep_last_y) begin
                  cy_in    = '0;
                  step_in  = STEP_RD_A;
                  state_in = (state_ff == ENG_CLEAR) ? ENG_LEVEL : ENG_CALC;
               end else begin
                  cy_in = cy_ff + ROW_W'(1);
               end
            end else begin
               cx_in = cx_ff + COL_W'(1);
            end
         end

         ENG_LEVEL: begin
            if ((lvl_ff == lvl_max_ff) || (w_ff[COL_W:1] == '0) || (h_ff[ROW_W:1] == '0)) begin
               ctl.done = 1'b1;
               state_in = ENG_IDLE;
            end else begin
               w_in     = w_ff >> 1;
               h_in     = h_ff >> 1;
               cy_in    = '0;
               cx_in    = '0;
               step_in  = STEP_RD_A;
               // the first level reads the image already in the work store
               state_in = (lvl_ff == '0) ? ENG_CALC : ENG_COPY;
            end
         end

         ENG_CALC: begin
            step_in = step_ff + STEP_W'(1);
            case (step_ff)
               STEP_RD_A: begin
                  work_rd_en   = 1'b1;
                  work_rd_addr = {row_even, col_even};
               end
               STEP_RD_B: begin
                  work_rd_en   = 1'b1;
                  work_rd_addr = {row_even, col_odd};
                  a_in         = work_rd_data_ff;
               end
               STEP_RD_C: begin
                  work_rd_en   = 1'b1;
                  work_rd_addr = {row_odd, col_even};
                  b_in         = work_rd_data_ff;
               end
               STEP_RD_D: begin
                  work_rd_en   = 1'b1;
                  work_rd_addr = {row_odd, col_odd};
                  c_in         = work_rd_data_ff;
               end
               STEP_GET_D: begin
                  d_in = work_rd_data_ff;
               end
               STEP_P: begin
                  p_in = alu_res;
               end
               STEP_Q: begin
                  alu_sub = 1'b1;
                  q_in    = alu_res;
               end
               STEP_R: begin
                  alu_a = SUM_W'(c_ff);
                  alu_b = SUM_W'(d_ff);
                  r_in  = alu_res;
               end
               STEP_S: begin
                  alu_a   = SUM_W'(c_ff);
                  alu_b   = SUM_W'(d_ff);
                  alu_sub = 1'b1;
                  s_in    = alu_res;
               end
               STEP_LL: begin
                  alu_a       = p_ff;
                  alu_b       = r_ff;
                  ctl.scr_wr  = 1'b1;
                  scr_wr_addr = {cy_ff, cx_ff};
               end
               STEP_LH: begin
                  alu_a       = p_ff;
                  alu_b       = r_ff;
                  alu_sub     = 1'b1;
                  ctl.scr_wr  = 1'b1;
                  scr_wr_addr = {row_low, cx_ff};
               end
               STEP_HL: begin
                  alu_a       = q_ff;
                  alu_b       = s_ff;
                  ctl.scr_wr  = 1'b1;
                  scr_wr_addr = {cy_ff, col_high};
               end
               STEP_HH: begin
                  alu_a       = q_ff;
                  alu_b       = s_ff;
                  alu_sub     = 1'b1;
                  ctl.scr_wr  = 1'b1;
                  scr_wr_addr = {row_low, col_high};
                  step_in     = STEP_RD_A;
                  if (blk_last_x) begin
                     cx_in = '0;
                     if (blk_last_y) begin
                        cy_in    = '0;
                        lvl_in   = lvl_ff + LVL_W'(1);
                        state_in = ENG_LEVEL;
                     end else begin
                        cy_in = cy_ff + ROW_W'(1);
                     end
                  end else begin
                     cx_in = cx_ff + COL_W'(1);
                  end
               end
               default: begin
                  step_in = STEP_RD_A;
               end
            endcase
            // floor divide by four
            scr_wr_data = STORE_W'(alu_res >>> 2);
         end

         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         step_ff  <= STEP_RD_A;
         sw_wr_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sw_wr_ff <= sw_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      cy_ff      <= cy_in;
      cx_ff      <= cx_in;
      h_ff       <= h_in;
      w_ff       <= w_in;
      lvl_ff     <= lvl_in;
      lvl_max_ff <= lvl_max_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      d_ff       <= d_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      s_ff       <= s_in;
      sw_src_ff  <= sw_src_in;
      sw_addr_ff <= sw_addr_in;
   end

   // work store: filled by the sweeps in the cycle after each source read
   always_ff @(posedge clock) begin
      if (sw_wr_ff) begin
         work_mem[sw_addr_ff] <= sw_src_ff ? scr_rd_data : img_rd_data;
      end
      if (work_rd_en) begin
         work_rd_data_ff <= work_mem[work_rd_addr];
      end
   end

endmodule

// ===== src/haar_wavelet_2d_forward.sv =====
// ----------------------------------------------------------------------------
// haar_wavelet_2d_forward
// Multi-level 2D Haar forward transform over a pixel store, quadrant layout.
// ----------------------------------------------------------------------------
// Pixel writes and coefficient reads are taken one per cycle while the
// transform is idle and the result path is not stalled; each gives its
// result word through the result stage and the output register. A start
// word holds req_ready low while the transform runs: one sweep clears the
// coefficient store and loads the image into the work memory, then each
// level k (band w = IMAGE_WIDTH>>k, h = IMAGE_HEIGHT>>k) runs its w*h blocks
// through the shared add/subtract unit, each level after the first having
// copied the previous band into the work memory through its single write
// port; the done word follows. Coefficients are signed, in 1/256 pixel units.
module haar_wavelet_2d_forward #(
   parameter int IMAGE_WIDTH  = haar2d_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = haar2d_pkg::DEF_IMAGE_HEIGHT,
   parameter int MAX_LEVELS   = haar2d_pkg::DEF_MAX_LEVELS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  haar2d_pkg::req_word_type         req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output haar2d_pkg::rsp_word_type         rsp_word,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [haar2d_pkg::LEVEL_W-1:0]   csr_data
);
   import haar2d_pkg::*;

   localparam int COL_W  = $clog2(IMAGE_WIDTH);
   localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int ROW_XW = (ROW_W > 8) ? ROW_W : 8;
   localparam int COL_XW = (COL_W > 8) ? COL_W : 8;

   logic [LEVEL_W-1:0] level_count_ff, level_count_in;

   logic               p1_valid_ff, p1_valid_in;
   logic [1:0]         p1_status_ff, p1_status_in;
   logic               p1_inside_ff, p1_inside_in;
   logic               p1_move;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               req_fire;
   logic               in_image;
   logic [ROW_XW-1:0]  row_x;
   logic [COL_XW-1:0]  col_x;
   logic [ADDR_W-1:0]  req_addr;

   logic [STORE_W-1:0] image_mem [DEPTH];
   logic [STORE_W-1:0] scratch_mem [DEPTH];
   logic [STORE_W-1:0] img_rd_data_ff;
   logic [STORE_W-1:0] scr_rd_data_ff;
   logic               scr_rd_en;
   logic [ADDR_W-1:0]  scr_rd_sel;

   eng_ctl_type        eng_ctl;
   logic [ADDR_W-1:0]  eng_img_rd_addr;
   logic [ADDR_W-1:0]  eng_scr_rd_addr;
   logic [ADDR_W-1:0]  eng_scr_wr_addr;
   logic [STORE_W-1:0] eng_scr_wr_data;
   logic               eng_start;

   haar2d_engine #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT),
      .MAX_LEVELS   (MAX_LEVELS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (eng_start),
      .level_count (level_count_ff),
      .img_rd_data (img_rd_data_ff),
      .scr_rd_data (scr_rd_data_ff),
      .ctl         (eng_ctl),
      .img_rd_addr (eng_img_rd_addr),
      .scr_rd_addr (eng_scr_rd_addr),
      .scr_wr_addr (eng_scr_wr_addr),
      .scr_wr_data (eng_scr_wr_data)
   );

   assign csr_ready = 1'b1;

   always_comb begin
      row_x    = ROW_XW'(req_word.row);
      col_x    = COL_XW'(req_word.column);
      req_addr = {row_x[ROW_W-1:0], col_x[COL_W-1:0]};
      in_image = (32'(req_word.row) < IMAGE_HEIGHT) && (32'(req_word.column) < IMAGE_WIDTH);

      // result stage moves on when the output register is free or is being read out
      p1_move   = p1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !eng_ctl.busy && (!p1_valid_ff || p1_move);
      req_fire  = req_valid && req_ready;
      eng_start = req_fire && (req_word.req_type == REQ_START);

      scr_rd_en  = eng_ctl.scr_rd || (req_fire && (req_word.req_type == REQ_READ));
      scr_rd_sel = eng_ctl.busy ? eng_scr_rd_addr : req_addr;

      level_count_in = (csr_valid && csr_ready) ? csr_data : level_count_ff;

      p1_valid_in  = p1_move ? 1'b0 : p1_valid_ff;
      p1_status_in = p1_status_ff;
      p1_inside_in = p1_inside_ff;
      if (req_fire && ((req_word.req_type == REQ_WRITE) || (req_word.req_type == REQ_READ))) begin
         p1_valid_in  = 1'b1;
         p1_status_in = (req_word.req_type == REQ_READ) ? STATUS_COEF : STATUS_STORED;
         p1_inside_in = in_image;
      end else if (eng_ctl.done) begin
         p1_valid_in  = 1'b1;
         p1_status_in = STATUS_DONE;
         p1_inside_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (p1_move) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in.status  = p1_status_ff;
         rsp_word_in.coefficient = ((p1_status_ff == STATUS_COEF) && p1_inside_ff)
                                   ? $signed(scr_rd_data_ff[COEF_W-1:0]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= LEVEL_RESET;
         p1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         level_count_ff <= level_count_in;
         p1_valid_ff    <= p1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_status_ff <= p1_status_in;
      p1_inside_ff <= p1_inside_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // pixels stored as value*256
   always_ff @(posedge clock) begin
      if (req_fire && (req_word.req_type == REQ_WRITE) && in_image) begin
         image_mem[req_addr] <= {2'b00, req_word.pixel_value, 8'h00};
      end
      if (eng_ctl.img_rd) begin
         img_rd_data_ff <= image_mem[eng_img_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (eng_ctl.scr_wr) begin
         scratch_mem[eng_scr_wr_addr] <= eng_scr_wr_data;
      end
      if (scr_rd_en) begin
         scr_rd_data_ff <= scratch_mem[scr_rd_sel];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
